@@ rtl/rgb_to_hsv_convert_defines.svh @@
// ---------------------------------------------------------------------------
// rgb_to_hsv_convert_defines
// Assertion macros used by the port-level checker of the RGB to HSV converter.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define RTV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define RTV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rtv_pkg.sv @@
// ---------------------------------------------------------------------------
// rtv_pkg
// Constants, sector codes and stage payload types of the RGB to HSV converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rtv_pkg;

  // Channel and result widths
  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 9;

  // Arithmetic constants
  localparam int unsigned HUE_SCALE = 60;
  localparam int unsigned SAT_SCALE = 255;
  localparam logic [HUE_W-1:0] HUE_OFS_GRN = 9'd120;
  localparam logic [HUE_W-1:0] HUE_OFS_BLU = 9'd240;
  localparam logic [HUE_W-1:0] HUE_WRAP    = 9'd360;

  // Divider shape: 8 quotient bits, 2 per stage
  localparam int unsigned NUM_W          = 16;
  localparam int unsigned QBITS          = 8;
  localparam int unsigned QIDX_W         = $clog2(QBITS);
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QBITS / BITS_PER_STAGE;

  // Whole pipe: two front stages, divider, output register
  localparam int unsigned NSTG = 2 + DIV_STAGES + 1;

  // Sector of the largest channel
  localparam logic [1:0] SEC_RED = 2'd0;
  localparam logic [1:0] SEC_GRN = 2'd1;
  localparam logic [1:0] SEC_BLU = 2'd2;

  // After min/max
  typedef struct packed {
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] chroma;
    logic [1:0]      sector;
    logic            neg;
    logic [CH_W-1:0] absdiff;
  } front_t;

  // Through the divider (hue and saturation side by side)
  typedef struct packed {
    logic [CH_W-1:0]  mx;
    logic             grey;
    logic [1:0]       sector;
    logic             neg;
    logic [NUM_W-1:0] hrem;
    logic [CH_W-1:0]  hdiv;
    logic [QBITS-1:0] hq;
    logic [NUM_W-1:0] srem;
    logic [QBITS-1:0] sq;
  } divw_t;

endpackage

`default_nettype wire

@@ rtl/rtv_if.sv @@
// ---------------------------------------------------------------------------
// rtv_if
// Valid/ready channels for RGB pixels and HSV results.
// ---------------------------------------------------------------------------
`default_nettype none

interface rtv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rtv_hsv_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/rgb_to_hsv_convert.sv @@
// ---------------------------------------------------------------------------
// rgb_to_hsv_convert
// 8-bit RGB pixel to hue (degrees), saturation and value, fully pipelined.
// ---------------------------------------------------------------------------
// One pixel beat is taken every clock while the output is not stalled, and
// each result beat passes through the stages in order: two front stages find max/min, the sector and the
// dividends, four divider stages each settle two quotient bits of both the
// hue and the saturation division, and a last stage applies the sector offset
// and drives the output register. Each stage holds its own valid bit and
// advances whenever the stage after it is empty or advancing, so bubbles
// close up and a stalled output holds its beat without loss; with out ready
// held high, in ready stays high.
`default_nettype none

module rgb_to_hsv_convert (
  input  logic      clk,
  input  logic      rst_n,
  rtv_pix_if.sink   in_pix,
  rtv_hsv_if.source out_hsv
);
  import rtv_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;
  divw_t           dat [DIV_STAGES+1];

  // Stage load enables, ripple back from the output
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_hsv.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_pix.ready = en[0];

  rtv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .red      (in_pix.red),
    .green    (in_pix.green),
    .blue     (in_pix.blue),
    .en       (en[1:0]),
    .vld      (vld[1:0]),
    .dat_o    (dat[0])
  );

  // Divider stages
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rtv_div_stage #(.StageIdx(g)) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld[g+1]),
      .dat_i (dat[g]),
      .en    (en[g+2]),
      .vld_o (vld[g+2]),
      .dat_o (dat[g+1])
    );
  end

  rtv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (vld[NSTG-2]),
    .dat_i      (dat[DIV_STAGES]),
    .en         (en[NSTG-1]),
    .vld_o      (vld[NSTG-1]),
    .hue        (out_hsv.hue),
    .saturation (out_hsv.saturation),
    .brightness (out_hsv.brightness)
  );

  assign out_hsv.valid = vld[NSTG-1];

endmodule

`default_nettype wire

@@ rtl/rtv_front.sv @@
// ---------------------------------------------------------------------------
// rtv_front
// Two stages: min/max and sector pick, then dividend forming.
// ---------------------------------------------------------------------------
`default_nettype none

module rtv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [1:0]         en,
  output logic [1:0]         vld,
  output rtv_pkg::divw_t     dat_o
);
  import rtv_pkg::*;

  front_t a_nxt, a_r;
  divw_t  b_nxt, b_r;
  logic [1:0] vld_r;

  // Stage A: largest, smallest, sector and the signed difference
  always_comb begin
    a_nxt.mx = red;
    if (green > a_nxt.mx) a_nxt.mx = green;
    if (blue > a_nxt.mx)  a_nxt.mx = blue;
    a_nxt.chroma = red;
    if (green < a_nxt.chroma) a_nxt.chroma = green;
    if (blue < a_nxt.chroma)  a_nxt.chroma = blue;
    a_nxt.chroma = a_nxt.mx - a_nxt.chroma;
    if (red >= green && red >= blue) begin
      a_nxt.sector  = SEC_RED;
      a_nxt.neg     = green < blue;
      a_nxt.absdiff = a_nxt.neg ? blue - green : green - blue;
    end else if (green >= blue) begin
      a_nxt.sector  = SEC_GRN;
      a_nxt.neg     = blue < red;
      a_nxt.absdiff = a_nxt.neg ? red - blue : blue - red;
    end else begin
      a_nxt.sector  = SEC_BLU;
      a_nxt.neg     = red < green;
      a_nxt.absdiff = a_nxt.neg ? green - red : red - green;
    end
  end

  // Stage B: dividends 60*|diff| and 255*chroma, quotients cleared
  always_comb begin
    b_nxt.mx     = a_r.mx;
    b_nxt.grey   = a_r.chroma == '0;
    b_nxt.sector = a_r.sector;
    b_nxt.neg    = a_r.neg;
    b_nxt.hrem   = NUM_W'(a_r.absdiff) * NUM_W'(HUE_SCALE);
    b_nxt.hdiv   = a_r.chroma;
    b_nxt.hq     = '0;
    b_nxt.srem   = NUM_W'(a_r.chroma) * NUM_W'(SAT_SCALE);
    b_nxt.sq     = '0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en[0]) a_r <= a_nxt;
    if (en[1]) b_r <= b_nxt;
  end

  assign vld   = vld_r;
  assign dat_o = b_r;

endmodule

`default_nettype wire

@@ rtl/rtv_div_stage.sv @@
// ---------------------------------------------------------------------------
// rtv_div_stage
// One divider stage: two restoring steps for hue and saturation quotients.
// ---------------------------------------------------------------------------
`default_nettype none

module rtv_div_stage #(
  parameter int unsigned StageIdx = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  rtv_pkg::divw_t dat_i,
  input  logic           en,
  output logic           vld_o,
  output rtv_pkg::divw_t dat_o
);
  import rtv_pkg::*;

  // Highest quotient bit settled here
  localparam int unsigned HiBit = QBITS - 1 - BITS_PER_STAGE * StageIdx;

  divw_t dat_nxt, dat_r;
  logic  vld_r;

  // Subtract the shifted divisor where it fits, one quotient bit per step
  always_comb begin
    logic [NUM_W-1:0] hsh;
    logic [NUM_W-1:0] ssh;
    dat_nxt = dat_i;
    for (int j = 0; j < BITS_PER_STAGE; j++) begin
      hsh = NUM_W'(dat_nxt.hdiv) << (HiBit - j);
      ssh = NUM_W'(dat_nxt.mx) << (HiBit - j);
      if (dat_nxt.hrem >= hsh) begin
        dat_nxt.hrem = dat_nxt.hrem - hsh;
        dat_nxt.hq[QIDX_W'(HiBit - j)] = 1'b1;
      end
      if (dat_nxt.srem >= ssh) begin
        dat_nxt.srem = dat_nxt.srem - ssh;
        dat_nxt.sq[QIDX_W'(HiBit - j)] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dat_r <= dat_nxt;
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

`default_nettype wire

@@ rtl/rtv_back.sv @@
// ---------------------------------------------------------------------------
// rtv_back
// Output stage: sector offset and sign fixup of hue, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rtv_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  rtv_pkg::divw_t dat_i,
  input  logic           en,
  output logic           vld_o,
  output logic [8:0]     hue,
  output logic [7:0]     saturation,
  output logic [7:0]     brightness
);
  import rtv_pkg::*;

  logic             vld_r;
  logic [HUE_W-1:0] hue_nxt, hue_r;
  logic [CH_W-1:0]  sat_nxt, sat_r;
  logic [CH_W-1:0]  bri_r;
  logic [HUE_W-1:0] q;
  logic [HUE_W-1:0] rnz;

  assign q   = HUE_W'(dat_i.hq);
  assign rnz = HUE_W'(dat_i.hrem != '0);

  // Red truncates toward zero and wraps; green and blue round down
  always_comb begin
    case (dat_i.sector)
      SEC_RED: begin
        if (!dat_i.neg)     hue_nxt = q;
        else if (q == '0)   hue_nxt = '0;
        else                hue_nxt = HUE_WRAP - q;
      end
      SEC_GRN: hue_nxt = dat_i.neg ? HUE_OFS_GRN - q - rnz : HUE_OFS_GRN + q;
      SEC_BLU: hue_nxt = dat_i.neg ? HUE_OFS_BLU - q - rnz : HUE_OFS_BLU + q;
      default: hue_nxt = '0;
    endcase
    if (dat_i.grey) hue_nxt = '0;
    sat_nxt = dat_i.grey ? '0 : dat_i.sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      bri_r <= dat_i.mx;
    end
  end

  assign vld_o      = vld_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign brightness = bri_r;

endmodule

`default_nettype wire

@@ rtl/rtv_chk.sv @@
// ---------------------------------------------------------------------------
// rtv_chk
// Port-level checks of the RGB to HSV converter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_hsv_convert_defines.svh"

module rtv_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] hue,
  input logic [7:0] saturation,
  input logic [7:0] brightness
);

  // A stalled result beat holds
  `RTV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({hue, saturation, brightness}), "result beat changed while stalled")

  // Hue stays within a turn
  `RTV_ASSERT_NOW(a_hue_range, out_valid, hue < 9'd360, "hue out of range")

  // Zero saturation only for grey pixels, which have zero hue
  `RTV_ASSERT_NOW(a_grey_hue, out_valid && saturation == 8'd0, hue == 9'd0,
    "nonzero hue on grey pixel")

  // Black has no saturation
  `RTV_ASSERT_NOW(a_black, out_valid && brightness == 8'd0, saturation == 8'd0,
    "saturation on black pixel")

  // An open output never blocks the input
  `RTV_ASSERT_NOW(a_flow, out_ready, in_ready, "input blocked while output is ready")

endmodule

bind rgb_to_hsv_convert rtv_chk u_rtv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_pix.ready),
  .out_valid  (out_hsv.valid),
  .out_ready  (out_hsv.ready),
  .hue        (out_hsv.hue),
  .saturation (out_hsv.saturation),
  .brightness (out_hsv.brightness)
);

`default_nettype wire
